// ===== hdl/rxla_pkg.sv =====
// rxla_pkg: shared types, codes and constants of the receive ring line assembler
`default_nettype none

package rxla_pkg;

    // ring size default
    localparam int RING_DEPTH_DEF = 256;

    // character codes
    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_LF = 8'h0A;

    // line length register
    localparam int          LEN_W         = 7;
    localparam int          CNT_W         = 6;
    localparam logic [LEN_W-1:0] LINE_LEN_CAP  = 7'd64;
    localparam logic [LEN_W-1:0] MAX_LEN_RESET = 7'd64;

    // request function codes
    localparam logic [1:0] FUNC_BYTE = 2'd0;
    localparam logic [1:0] FUNC_LINE = 2'd1;
    localparam logic [1:0] FUNC_ECHO = 2'd2;

    // result kind codes
    localparam logic [2:0] KIND_STORED     = 3'd0;
    localparam logic [2:0] KIND_DROPPED    = 3'd1;
    localparam logic [2:0] KIND_LINE_CHAR  = 3'd2;
    localparam logic [2:0] KIND_LINE_DONE  = 3'd3;
    localparam logic [2:0] KIND_NO_LINE    = 3'd4;
    localparam logic [2:0] KIND_ECHO_BYTE  = 3'd5;
    localparam logic [2:0] KIND_ECHO_EMPTY = 3'd6;

    // request and result payloads
    typedef struct packed {
        logic [1:0] func;
        logic [7:0] rx_byte;
    } in_req_t;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] data;
        logic       last;
    } out_res_t;

    // result data source
    typedef enum logic [1:0] {
        DSEL_ZERO,
        DSEL_RD,
        DSEL_COUNT,
        DSEL_LF
    } dsel_t;

    // controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN_ADDR,
        ST_SCAN_CHK,
        ST_COPY_ADDR,
        ST_COPY_EMIT,
        ST_SKIP_ADDR,
        ST_SKIP_CHK,
        ST_ECHO_EMIT,
        ST_ECHO_LF
    } state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic     wr_byte;
        logic     idx_load_line;
        logic     idx_load_end_next;
        logic     idx_inc;
        logic     end_capture;
        logic     rd_en;
        logic     rd_echo;
        logic     echo_adv;
        logic     line_set;
        logic     line_next;
        logic     count_inc;
        logic     emit;
        logic [2:0] emit_kind;
        dsel_t    emit_dsel;
        logic     emit_last;
    } dp_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic full;
        logic idx_at_head;
        logic idx_at_end;
        logic count_at_limit;
        logic echo_at_head;
        logic rd_is_term;
        logic rd_is_cr;
    } dp_stat_t;

endpackage

`default_nettype wire

// ===== hdl/rxla_datapath.sv =====
// rxla_datapath: ring memory, pointers, line counters and result register
`default_nettype none

module rxla_datapath #(
    parameter int RING_DEPTH = rxla_pkg::RING_DEPTH_DEF
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire rxla_pkg::in_req_t      req,
    input  wire logic                   cfg_we,
    input  wire logic [rxla_pkg::LEN_W-1:0] cfg_wdata,
    input  wire rxla_pkg::dp_cmd_t      cmd,
    output rxla_pkg::dp_stat_t          stat,
    output logic                        res_strobe,
    output rxla_pkg::out_res_t          res
);
    import rxla_pkg::*;

    localparam int PTR_W = $clog2(RING_DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);

    logic [7:0]       ring_mem [0:RING_DEPTH-1];
    logic [7:0]       rd_data_reg;
    logic [PTR_W-1:0] wr_ptr_reg, line_ptr_reg, echo_ptr_reg, idx_reg, end_reg;
    logic [PTR_W-1:0] wr_ptr_next, line_ptr_next, echo_ptr_next, idx_next, end_next;
    logic [PTR_W-1:0] rd_addr;
    logic [CNT_W-1:0] count_reg, count_next, limit;
    logic [LEN_W-1:0] max_len_reg, len_cap;
    logic             res_strobe_reg;
    out_res_t         res_reg, res_next;

    // wrap a pointer modulo the ring depth
    function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
        next_ptr = (p == PTR_LAST) ? '0 : p + 1'b1;
    endfunction

    // ring memory, one write and one registered read
    assign rd_addr = cmd.rd_echo ? echo_ptr_reg : idx_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.wr_byte)
        begin
            ring_mem[wr_ptr_reg] <= req.rx_byte;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= ring_mem[rd_addr];
        end
    end

    // line length limit: capped, one place kept for the terminator
    assign len_cap = (max_len_reg > LINE_LEN_CAP) ? LINE_LEN_CAP : max_len_reg;
    assign limit   = (len_cap == '0) ? '0 : CNT_W'(len_cap - 1'b1);

    // pointer and counter next values
    always_comb
    begin
        wr_ptr_next   = cmd.wr_byte ? next_ptr(wr_ptr_reg) : wr_ptr_reg;
        echo_ptr_next = cmd.echo_adv ? next_ptr(echo_ptr_reg) : echo_ptr_reg;
        end_next      = cmd.end_capture ? idx_reg : end_reg;
        line_ptr_next = line_ptr_reg;
        if (cmd.line_set)
        begin
            line_ptr_next = cmd.line_next ? next_ptr(idx_reg) : idx_reg;
        end
        idx_next = idx_reg;
        if (cmd.idx_load_line)
        begin
            idx_next = line_ptr_reg;
        end
        else if (cmd.idx_load_end_next)
        begin
            idx_next = next_ptr(end_reg);
        end
        else if (cmd.idx_inc)
        begin
            idx_next = next_ptr(idx_reg);
        end
        count_next = count_reg;
        if (cmd.idx_load_line)
        begin
            count_next = '0;
        end
        else if (cmd.count_inc)
        begin
            count_next = count_reg + 1'b1;
        end
    end

    // result payload
    always_comb
    begin
        res_next.kind = cmd.emit_kind;
        res_next.last = cmd.emit_last;
        case (cmd.emit_dsel)
            DSEL_ZERO:  res_next.data = 8'h00;
            DSEL_RD:    res_next.data = rd_data_reg;
            DSEL_COUNT: res_next.data = 8'(count_reg);
            DSEL_LF:    res_next.data = CHAR_LF;
            default:    res_next.data = 8'h00;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg     <= '0;
            line_ptr_reg   <= '0;
            echo_ptr_reg   <= '0;
            idx_reg        <= '0;
            end_reg        <= '0;
            count_reg      <= '0;
            max_len_reg    <= MAX_LEN_RESET;
            res_strobe_reg <= 1'b0;
        end
        else
        begin
            wr_ptr_reg     <= wr_ptr_next;
            line_ptr_reg   <= line_ptr_next;
            echo_ptr_reg   <= echo_ptr_next;
            idx_reg        <= idx_next;
            end_reg        <= end_next;
            count_reg      <= count_next;
            res_strobe_reg <= cmd.emit;
            if (cfg_we)
            begin
                max_len_reg <= cfg_wdata;
            end
        end
    end

    // result payload register
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            res_reg <= res_next;
        end
    end

    // status to controller
    always_comb
    begin
        stat.full           = (next_ptr(wr_ptr_reg) == line_ptr_reg);
        stat.idx_at_head    = (idx_reg == wr_ptr_reg);
        stat.idx_at_end     = (idx_reg == end_reg);
        stat.count_at_limit = (count_reg == limit);
        stat.echo_at_head   = (echo_ptr_reg == wr_ptr_reg);
        stat.rd_is_term     = (rd_data_reg == CHAR_CR) || (rd_data_reg == CHAR_LF);
        stat.rd_is_cr       = (rd_data_reg == CHAR_CR);
    end

    assign res_strobe = res_strobe_reg;
    assign res        = res_reg;

endmodule

`default_nettype wire

// ===== hdl/rxla_ctrl.sv =====
// rxla_ctrl: request sequencer for byte store, line read and echo
`default_nettype none

module rxla_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic [1:0]         func,
    input  wire rxla_pkg::dp_stat_t stat,
    output logic                    busy,
    output rxla_pkg::dp_cmd_t       cmd
);
    import rxla_pkg::*;

    state_t state_reg, state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    case (func)
                        FUNC_BYTE:
                        begin
                            cmd.emit      = 1'b1;
                            cmd.emit_last = 1'b1;
                            cmd.emit_kind = stat.full ? KIND_DROPPED : KIND_STORED;
                            cmd.wr_byte   = !stat.full;
                        end
                        FUNC_LINE:
                        begin
                            cmd.idx_load_line = 1'b1;
                            state_next        = ST_SCAN_ADDR;
                        end
                        FUNC_ECHO:
                        begin
                            if (stat.echo_at_head)
                            begin
                                cmd.emit      = 1'b1;
                                cmd.emit_last = 1'b1;
                                cmd.emit_kind = KIND_ECHO_EMPTY;
                            end
                            else
                            begin
                                cmd.rd_en   = 1'b1;
                                cmd.rd_echo = 1'b1;
                                state_next  = ST_ECHO_EMIT;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            // look for a terminator between tail and head
            ST_SCAN_ADDR:
            begin
                if (stat.idx_at_head)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_last = 1'b1;
                    cmd.emit_kind = KIND_NO_LINE;
                    state_next    = ST_IDLE;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    state_next = ST_SCAN_CHK;
                end
            end
            ST_SCAN_CHK:
            begin
                if (stat.rd_is_term)
                begin
                    cmd.end_capture   = 1'b1;
                    cmd.idx_load_line = 1'b1;
                    state_next        = ST_COPY_ADDR;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = ST_SCAN_ADDR;
                end
            end
            // copy characters up to the terminator or the limit
            ST_COPY_ADDR:
            begin
                if (stat.idx_at_end || stat.count_at_limit)
                begin
                    cmd.emit              = 1'b1;
                    cmd.emit_last         = 1'b1;
                    cmd.emit_kind         = KIND_LINE_DONE;
                    cmd.emit_dsel         = DSEL_COUNT;
                    cmd.idx_load_end_next = 1'b1;
                    state_next            = ST_SKIP_ADDR;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    state_next = ST_COPY_EMIT;
                end
            end
            ST_COPY_EMIT:
            begin
                cmd.emit      = 1'b1;
                cmd.emit_kind = KIND_LINE_CHAR;
                cmd.emit_dsel = DSEL_RD;
                cmd.count_inc = 1'b1;
                cmd.idx_inc   = 1'b1;
                state_next    = ST_COPY_ADDR;
            end
            // step the tail past the terminator and one more cr or lf
            ST_SKIP_ADDR:
            begin
                if (stat.idx_at_head)
                begin
                    cmd.line_set = 1'b1;
                    state_next   = ST_IDLE;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    state_next = ST_SKIP_CHK;
                end
            end
            ST_SKIP_CHK:
            begin
                cmd.line_set  = 1'b1;
                cmd.line_next = stat.rd_is_term;
                state_next    = ST_IDLE;
            end
            // echo one byte, lf after cr
            ST_ECHO_EMIT:
            begin
                cmd.emit      = 1'b1;
                cmd.emit_kind = KIND_ECHO_BYTE;
                cmd.emit_dsel = DSEL_RD;
                cmd.emit_last = !stat.rd_is_cr;
                cmd.echo_adv  = 1'b1;
                state_next    = stat.rd_is_cr ? ST_ECHO_LF : ST_IDLE;
            end
            ST_ECHO_LF:
            begin
                cmd.emit      = 1'b1;
                cmd.emit_kind = KIND_ECHO_BYTE;
                cmd.emit_dsel = DSEL_LF;
                cmd.emit_last = 1'b1;
                state_next    = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

`default_nettype wire

// ===== hdl/rx_ring_line_assembler.sv =====
// rx_ring_line_assembler: top level of the receive ring line assembler
//
// Requests are taken on start while busy is low; req carries func and rx_byte.
// func byte stores rx_byte at the head of the ring, or drops it when the ring
// is full, and reports which; busy stays low, so a new request may follow
// in the next cycle.
// func line scans from the tail for cr or lf and returns the line characters,
// then a done result with the count, or a single no-line result. It takes the
// request, reads and checks each scanned byte, reads and emits each copied
// character, gives the done result and steps past the terminator pair; the
// ring memory read is registered. busy is high for the whole read.
// func echo returns the next unechoed byte, plus lf after cr, or echo-empty.
// Each result is shown on res for one cycle with res_strobe high, in the
// cycle after the step that makes it; the receiver cannot stall and takes
// every result. cfg_we writes max_line_len from cfg_wdata; the user must
// write it only while the block is idle, which the block does not enforce.
// Reset clears all pointers and sets max_line_len to 64; the ring contents
// are undefined until written and need no clearing pass.
`default_nettype none

module rx_ring_line_assembler #(
    parameter int RING_DEPTH = rxla_pkg::RING_DEPTH_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    output logic                            busy,
    input  wire rxla_pkg::in_req_t          req,
    input  wire logic                       cfg_we,
    input  wire logic [rxla_pkg::LEN_W-1:0] cfg_wdata,
    output logic                            res_strobe,
    output rxla_pkg::out_res_t              res
);
    import rxla_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // request sequencer
    rxla_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .func  (req.func),
        .stat  (stat),
        .busy  (busy),
        .cmd   (cmd)
    );

    // ring and pointers
    rxla_datapath #(
        .RING_DEPTH (RING_DEPTH)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .cmd        (cmd),
        .stat       (stat),
        .res_strobe (res_strobe),
        .res        (res)
    );

endmodule

`default_nettype wire

// ===== hdl/rxla_checker.sv =====
// rxla_checker: port-level assertions for the receive ring line assembler, with bind
`default_nettype none

module rxla_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               start,
    input wire logic               busy,
    input wire rxla_pkg::in_req_t  req,
    input wire logic               res_strobe,
    input wire rxla_pkg::out_res_t res
);
    import rxla_pkg::*;

    // a byte request answers in the next cycle with one final status
    a_byte_status: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && req.func == FUNC_BYTE) |=>
            (res_strobe && res.last &&
             (res.kind == KIND_STORED || res.kind == KIND_DROPPED)))
        else $error("byte request without a status result");

    // a line read keeps the block busy
    a_line_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && req.func == FUNC_LINE) |=> busy)
        else $error("line read did not raise busy");

    // no result appears without a request in progress
    a_no_stray: assert property (@(posedge clk) disable iff (!rst_n)
        res_strobe |-> $past(busy || start))
        else $error("result without a request");

    // a line character is never the final result of a request
    a_char_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (res_strobe && res.kind == KIND_LINE_CHAR) |-> !res.last)
        else $error("line character marked last");

endmodule

bind rx_ring_line_assembler rxla_checker u_rxla_checker (.*);

`default_nettype wire
